### src/cbcs_pkg.sv
// Package for the cubic Bezier curve sampler.
// Holds default parameters, register widths and the sequencer state type.
// No dependencies.
package cbcs_pkg;

	localparam int MAX_SAMPLES_DEF = 64;
	localparam int COORD_WIDTH_DEF = 16;
	localparam int T_FRAC_BITS_DEF = 16;

	localparam int CFG_WIDTH  = 7;
	localparam int SNUM_WIDTH = 6;
	localparam logic [CFG_WIDTH-1:0] SPC_RESET = 7'd50;

	typedef enum logic [1:0] {
		SEQ_IDLE,
		SEQ_DIV,
		SEQ_GEN
	} seq_state_t;

endpackage

### src/cbcs_horner_step.sv
// One Horner step acc*t + addend, two register stages.
// Stage 1 forms split partial products, stage 2 recombines and adds. No dependencies.
module cbcs_horner_step #(
	parameter int IW = 20,
	parameter int TW = 16,
	parameter int AW = 36,
	parameter int OW = 37
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [IW-1:0] acc,
	input  logic        [TW-1:0] t,
	input  logic signed [AW-1:0] addend,
	output logic signed [OW-1:0] res
);

	localparam int LO = IW / 2;
	localparam int HI = IW - LO;

	logic        [LO+TW-1:0] lo_s1;
	logic signed [HI+TW:0]   hi_s1;
	logic signed [AW-1:0]    add_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			lo_s1  <= acc[LO-1:0] * t;
			hi_s1  <= $signed(acc[IW-1:LO]) * $signed({1'b0, t});
			add_s1 <= addend;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res <= (OW'(hi_s1) << LO) + OW'(lo_s1) + OW'(add_s1);
		end
	end

endmodule

### src/cubic_bezier_curve_sampler_top.sv
// Top level of the cubic Bezier curve sampler: sequencer, t step divider, pipeline.
// Depends on cbcs_pkg and cbcs_horner_step.
//
// channel  dir  handshake              payload
// curve    in   curve_valid/stall      p0_x p0_y p1_x p1_y p2_x p2_y p3_x p3_y
// point    out  point_valid/stall      point_x point_y sample_number clipped last_sample
// cfg      in   cfg_valid/cfg_ready    cfg_data (samples_per_curve)
//
// A curve is accepted in an idle cycle, passes through the bit-serial t step divider, then
// issues N samples, one per cycle while point_stall does not freeze the pipeline, into a
// 7-stage pipeline (three split Horner steps with rounding, saturate).
// curve_stall is high from acceptance until the last sample is issued.
// Reset is asynchronous; no clearing pass. A point_stall on a waiting word freezes the pipeline.
module cubic_bezier_curve_sampler_top #(
	parameter int MAX_SAMPLES = cbcs_pkg::MAX_SAMPLES_DEF,
	parameter int COORD_WIDTH = cbcs_pkg::COORD_WIDTH_DEF,
	parameter int T_FRAC_BITS = cbcs_pkg::T_FRAC_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               curve_valid,
	output logic                               curve_stall,
	input  logic signed [COORD_WIDTH-1:0]      p0_x,
	input  logic signed [COORD_WIDTH-1:0]      p0_y,
	input  logic signed [COORD_WIDTH-1:0]      p1_x,
	input  logic signed [COORD_WIDTH-1:0]      p1_y,
	input  logic signed [COORD_WIDTH-1:0]      p2_x,
	input  logic signed [COORD_WIDTH-1:0]      p2_y,
	input  logic signed [COORD_WIDTH-1:0]      p3_x,
	input  logic signed [COORD_WIDTH-1:0]      p3_y,
	output logic                               point_valid,
	input  logic                               point_stall,
	output logic signed [COORD_WIDTH-1:0]      point_x,
	output logic signed [COORD_WIDTH-1:0]      point_y,
	output logic [cbcs_pkg::SNUM_WIDTH-1:0]    sample_number,
	output logic                               clipped,
	output logic                               last_sample,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [cbcs_pkg::CFG_WIDTH-1:0]     cfg_data
);

	localparam int CW   = COORD_WIDTH;
	localparam int F    = T_FRAC_BITS;
	localparam int KW   = CW + 4;
	localparam int W1   = KW + F + 1;
	localparam int W2   = W1 + F + 1;
	localparam int W3   = W2 + F + 1;
	localparam int SW   = W3 - 3 * F;
	localparam int NW   = $clog2(MAX_SAMPLES + 1);
	localparam int CNTW = $clog2(MAX_SAMPLES);
	localparam int DCW  = $clog2(F + 1);

	cbcs_pkg::seq_state_t state_q, state_nx;

	logic [cbcs_pkg::CFG_WIDTH-1:0] spc_q;
	logic [NW-1:0]   n_eff, n_q;
	logic [DCW-1:0]  dcnt_q;
	logic [NW-1:0]   div_rem_q, div_rem_nx, r_q;
	logic [NW:0]     rem_sh;
	logic            div_ge;
	logic [F:0]      q_q, t_inc;
	logic [F-1:0]    t_q, t_nx;
	logic [NW-1:0]   ph_q, ph_nx;
	logic [NW:0]     ph_sum;
	logic            ph_ge;
	logic [CNTW-1:0] cnt_q;
	logic            last_now;
	logic            issue, en;

	logic signed [CW-1:0] pin0[2], pin1[2], pin2[2], pin3[2];
	logic signed [CW-1:0] p0_q[2], p1_q[2], p2_q[2], p3_q[2];
	logic signed [KW-1:0] a_q[2], b_q[2], c_q[2];

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic [F-1:0] t_s1, t_s2, t_s3, t_s4;
	logic signed [KW-1:0] c_s1[2], c_s2[2];
	logic signed [CW-1:0] p0_s1[2], p0_s2[2], p0_s3[2], p0_s4[2];
	logic [CNTW-1:0] idx_s1, idx_s2, idx_s3, idx_s4, idx_s5, idx_s6;
	logic last_s1, last_s2, last_s3, last_s4, last_s5, last_s6;
	logic signed [W1-1:0] r1[2];
	logic signed [W2-1:0] r2[2];
	logic signed [W3-1:0] r3[2];
	logic [CW:0] satx, saty;
	logic [31:0] idx_ext;

	assign pin0[0] = p0_x;
	assign pin0[1] = p0_y;
	assign pin1[0] = p1_x;
	assign pin1[1] = p1_y;
	assign pin2[0] = p2_x;
	assign pin2[1] = p2_y;
	assign pin3[0] = p3_x;
	assign pin3[1] = p3_y;

	assign cfg_ready = 1'b1;
	assign en = !v_s7 || !point_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spc_q <= cbcs_pkg::SPC_RESET;
		end else if (cfg_valid && cfg_ready) begin
			spc_q <= cfg_data;
		end
	end

	always_comb begin
		if (spc_q == '0) begin
			n_eff = NW'(1);
		end else if (32'(spc_q) > 32'(MAX_SAMPLES)) begin
			n_eff = NW'(MAX_SAMPLES);
		end else begin
			n_eff = NW'(spc_q);
		end
	end

	// restoring divide of 2^F by n, one quotient bit per cycle
	always_comb begin
		rem_sh     = {div_rem_q, (dcnt_q == DCW'(F))};
		div_ge     = rem_sh >= {1'b0, n_q};
		div_rem_nx = div_ge ? NW'(rem_sh - {1'b0, n_q}) : NW'(rem_sh);
	end

	// t advances by q, plus one when the fractional phase wraps
	always_comb begin
		ph_sum = {1'b0, ph_q} + {1'b0, r_q};
		ph_ge  = ph_sum >= {1'b0, n_q};
		ph_nx  = ph_ge ? NW'(ph_sum - {1'b0, n_q}) : NW'(ph_sum);
		t_inc  = q_q + (F+1)'(ph_ge);
		t_nx   = F'((F+1)'(t_q) + t_inc);
	end

	assign last_now = NW'(cnt_q) == (n_q - NW'(1));

	always_comb begin
		state_nx = state_q;
		case (state_q)
			cbcs_pkg::SEQ_IDLE: begin
				if (curve_valid) state_nx = cbcs_pkg::SEQ_DIV;
			end
			cbcs_pkg::SEQ_DIV: begin
				if (dcnt_q == '0) state_nx = cbcs_pkg::SEQ_GEN;
			end
			cbcs_pkg::SEQ_GEN: begin
				if (en && last_now) state_nx = cbcs_pkg::SEQ_IDLE;
			end
			default: state_nx = cbcs_pkg::SEQ_IDLE;
		endcase
	end

	always_comb begin
		curve_stall = 1'b1;
		issue       = 1'b0;
		case (state_q)
			cbcs_pkg::SEQ_IDLE: curve_stall = 1'b0;
			cbcs_pkg::SEQ_DIV:  curve_stall = 1'b1;
			cbcs_pkg::SEQ_GEN:  issue = en;
			default:            curve_stall = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= cbcs_pkg::SEQ_IDLE;
			n_q       <= NW'(1);
			dcnt_q    <= '0;
			div_rem_q <= '0;
			q_q       <= '0;
			r_q       <= '0;
			t_q       <= '0;
			ph_q      <= '0;
			cnt_q     <= '0;
		end else begin
			state_q <= state_nx;
			if (state_q == cbcs_pkg::SEQ_IDLE && curve_valid) begin
				n_q       <= n_eff;
				dcnt_q    <= DCW'(F);
				div_rem_q <= '0;
				q_q       <= '0;
				t_q       <= '0;
				ph_q      <= '0;
				cnt_q     <= '0;
			end
			if (state_q == cbcs_pkg::SEQ_DIV) begin
				dcnt_q    <= dcnt_q - DCW'(1);
				div_rem_q <= div_rem_nx;
				q_q       <= {q_q[F-1:0], div_ge};
				r_q       <= div_rem_nx;
			end
			if (issue) begin
				t_q   <= t_nx;
				ph_q  <= ph_nx;
				cnt_q <= cnt_q + CNTW'(1);
			end
		end
	end

	for (genvar ax = 0; ax < 2; ax++) begin : g_axis
		logic signed [KW-1:0] d0, d1, d2, s;

		always_ff @(posedge clk) begin
			if (state_q == cbcs_pkg::SEQ_IDLE && curve_valid) begin
				p0_q[ax] <= pin0[ax];
				p1_q[ax] <= pin1[ax];
				p2_q[ax] <= pin2[ax];
				p3_q[ax] <= pin3[ax];
			end
		end

		always_comb begin
			d0 = KW'(p1_q[ax]) - KW'(p0_q[ax]);
			d1 = KW'(p1_q[ax]) - KW'(p2_q[ax]);
			d2 = KW'(p3_q[ax]) - KW'(p0_q[ax]);
			s  = KW'(p0_q[ax]) + KW'(p2_q[ax]) - (KW'(p1_q[ax]) <<< 1);
		end

		// a = p3-p0+3(p1-p2), b = 3(p0-2p1+p2), c = 3(p1-p0)
		always_ff @(posedge clk) begin
			if (state_q == cbcs_pkg::SEQ_DIV) begin
				a_q[ax] <= d2 + d1 + (d1 <<< 1);
				b_q[ax] <= s + (s <<< 1);
				c_q[ax] <= d0 + (d0 <<< 1);
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				c_s1[ax]  <= c_q[ax];
				c_s2[ax]  <= c_s1[ax];
				p0_s1[ax] <= p0_q[ax];
				p0_s2[ax] <= p0_s1[ax];
				p0_s3[ax] <= p0_s2[ax];
				p0_s4[ax] <= p0_s3[ax];
			end
		end

		cbcs_horner_step #(.IW(KW), .TW(F), .AW(KW + F), .OW(W1)) u_step1 (
			.clk    (clk),
			.en     (en),
			.acc    (a_q[ax]),
			.t      (t_q),
			.addend ($signed({b_q[ax], {F{1'b0}}})),
			.res    (r1[ax])
		);

		cbcs_horner_step #(.IW(W1), .TW(F), .AW(KW + 2 * F), .OW(W2)) u_step2 (
			.clk    (clk),
			.en     (en),
			.acc    (r1[ax]),
			.t      (t_s2),
			.addend ($signed({c_s2[ax], {(2 * F){1'b0}}})),
			.res    (r2[ax])
		);

		// rounding half folded into the p0 addend
		cbcs_horner_step #(.IW(W2), .TW(F), .AW(CW + 3 * F), .OW(W3)) u_step3 (
			.clk    (clk),
			.en     (en),
			.acc    (r2[ax]),
			.t      (t_s4),
			.addend ($signed({p0_s4[ax], 1'b1, {(3 * F - 1){1'b0}}})),
			.res    (r3[ax])
		);
	end

	function automatic logic [CW:0] sat_axis(input logic signed [W3-1:0] v);
		logic [SW-1:0] hi;
		logic [CW:0]   r;
		hi = v[W3-1:3*F];
		if ((&hi[SW-1:CW-1]) || !(|hi[SW-1:CW-1])) begin
			r = {1'b0, hi[CW-1:0]};
		end else if (hi[SW-1]) begin
			r = {2'b11, {(CW-1){1'b0}}};
		end else begin
			r = {2'b10, {(CW-1){1'b1}}};
		end
		return r;
	endfunction

	assign satx = sat_axis(r3[0]);
	assign saty = sat_axis(r3[1]);

	always_ff @(posedge clk) begin
		if (en) begin
			t_s1    <= t_q;
			t_s2    <= t_s1;
			t_s3    <= t_s2;
			t_s4    <= t_s3;
			idx_s1  <= cnt_q;
			idx_s2  <= idx_s1;
			idx_s3  <= idx_s2;
			idx_s4  <= idx_s3;
			idx_s5  <= idx_s4;
			idx_s6  <= idx_s5;
			last_s1 <= last_now;
			last_s2 <= last_s1;
			last_s3 <= last_s2;
			last_s4 <= last_s3;
			last_s5 <= last_s4;
			last_s6 <= last_s5;
		end
	end

	assign idx_ext = 32'(idx_s6);

	always_ff @(posedge clk) begin
		if (en) begin
			point_x       <= satx[CW-1:0];
			point_y       <= saty[CW-1:0];
			clipped       <= satx[CW] | saty[CW];
			sample_number <= idx_ext[cbcs_pkg::SNUM_WIDTH-1:0];
			last_sample   <= last_s6;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	assign point_valid = v_s7;

	a_ph_below_n: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == cbcs_pkg::SEQ_GEN |-> ph_q < n_q)
		else $error("t phase not below sample count");

	a_cnt_below_n: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == cbcs_pkg::SEQ_GEN |-> NW'(cnt_q) < n_q)
		else $error("sample counter past sample count");

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == cbcs_pkg::SEQ_DIV |-> div_rem_q < n_q && n_q != '0)
		else $error("divider remainder out of range");

	a_issue_gen: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(v_s1) |-> $past(state_q) == cbcs_pkg::SEQ_GEN)
		else $error("sample issued outside generate state");

endmodule
